// ===== hw/rtl/snapshot_interpolation_buffer_unit_assert.svh =====
// Assertion macros used by the snapshot buffer checker
`ifndef SNAPSHOT_INTERPOLATION_BUFFER_UNIT_ASSERT_SVH
`define SNAPSHOT_INTERPOLATION_BUFFER_UNIT_ASSERT_SVH
// same-cycle implication, clocked on clk and disabled in reset
`define SIB_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("snapshot buffer check failed");
// next-cycle implication
`define SIB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("snapshot buffer check failed");
`endif

// ===== hw/rtl/sib_pkg.sv =====
// Shared constants, types and command/status bundles of the snapshot buffer
package sib_pkg;

    localparam int DEPTH          = 64;
    localparam int SLOT_W         = $clog2(DEPTH);
    localparam int CNT_W          = $clog2(DEPTH + 1);
    localparam int TICK_FRAC_BITS = 8;
    localparam int TICK_W         = 32;
    localparam int QT_W           = 40;
    localparam int POS_W          = 32;
    localparam int ANG_W          = 16;
    localparam int FLAG_W         = 8;
    localparam int REQ_W          = 2;
    localparam int T_W            = 16;
    localparam int QUO_W          = T_W + 1;
    localparam int BIT_W          = $clog2(QUO_W);
    localparam int NUM_W          = QT_W + T_W - TICK_FRAC_BITS;
    localparam int REM_W          = NUM_W + 1;
    localparam int LANES          = 5;
    localparam int LANE_W         = $clog2(LANES);
    localparam int TWO_PI_Q12     = 25736;
    localparam int PI_Q12         = 12868;

    localparam logic [REQ_W-1:0] REQ_PUSH   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_SAMPLE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_PRUNE  = 2'd2;
    localparam logic [REQ_W-1:0] REQ_NOP    = 2'd3;

    localparam logic [1:0] RD_FIRST  = 2'd0;
    localparam logic [1:0] RD_LAST   = 2'd1;
    localparam logic [1:0] RD_SCAN   = 2'd2;
    localparam logic [1:0] RD_SECOND = 2'd3;

    localparam logic [1:0] OUT_NONE   = 2'd0;
    localparam logic [1:0] OUT_PUSH   = 2'd1;
    localparam logic [1:0] OUT_ENTRY  = 2'd2;
    localparam logic [1:0] OUT_INTERP = 2'd3;

    typedef struct packed {
        logic [TICK_W-1:0]       tick;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
        logic signed [ANG_W-1:0] yaw;
        logic signed [ANG_W-1:0] pitch;
        logic [FLAG_W-1:0]       flags;
    } entry_t;

    typedef struct packed {
        logic       load;
        logic       rd_en;
        logic [1:0] rd_sel;
        logic       ent_a_ld;
        logic       ent_b_ld;
        logic       k_set;
        logic       k_inc;
        logic       div_init;
        logic       div_step;
        logic       lane_clr;
        logic       lane_inc;
        logic       lane_d;
        logic       lane_m;
        logic       lane_a;
        logic       wr_en;
        logic       advance;
        logic       fin;
        logic [1:0] out_sel;
    } dp_cmd_t;

    typedef struct packed {
        logic [REQ_W-1:0] req;
        logic             empty;
        logic             multi;
        logic             q_le;
        logic             q_ge;
        logic             push_newer;
        logic             prune_ok;
        logic             div_last;
        logic             lane_last;
    } dp_stat_t;

endpackage

// ===== hw/rtl/snapshot_interpolation_buffer_unit.sv =====
// Top level of the snapshot interpolation buffer
// Ring of up to DEPTH timestamped snapshots. Raise start with an item while
// busy is low; busy stays high until the result, which appears for exactly one
// cycle with done high and cannot be held off. Every item yields one result,
// with entry_count giving the fill after the operation. Items run one at a
// time through the ring memory with registered read:
//   push   reads the newest tick, then writes the snapshot if it is newer;
//          an empty ring takes it without the read,
//   prune  drops the oldest entry while the second entry is not later than
//          the tick, and stops at a single entry,
//   sample gives no hit when empty and returns the end entry when clamped to
//          an end; otherwise the linear bracket scan reads and checks one
//          entry at a time, the restoring divider forms t, and a shared
//          multiplier mixes the five lanes one by one, each by difference,
//          multiply and add.
// Query ticks carry TICK_FRAC_BITS fraction bits; prune uses the integer part.
// Fields a request does not define read as zero.
module snapshot_interpolation_buffer_unit import sib_pkg::*; (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [REQ_W-1:0]         req_type,
    input  logic [TICK_W-1:0]        snap_tick,
    input  logic [QT_W-1:0]          query_tick,
    input  logic signed [POS_W-1:0]  in_pos_x,
    input  logic signed [POS_W-1:0]  in_pos_y,
    input  logic signed [POS_W-1:0]  in_pos_z,
    input  logic signed [ANG_W-1:0]  in_yaw,
    input  logic signed [ANG_W-1:0]  in_pitch,
    input  logic [FLAG_W-1:0]        in_flags,
    output logic                     done,
    output logic                     hit,
    output logic                     accepted,
    output logic [TICK_W-1:0]        out_tick,
    output logic signed [POS_W-1:0]  out_pos_x,
    output logic signed [POS_W-1:0]  out_pos_y,
    output logic signed [POS_W-1:0]  out_pos_z,
    output logic signed [ANG_W-1:0]  out_yaw,
    output logic signed [ANG_W-1:0]  out_pitch,
    output logic [FLAG_W-1:0]        out_flags,
    output logic [CNT_W-1:0]         entry_count
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // sequence each item: dispatch, memory reads, divide, mix, finish
    sib_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .cmd   (cmd)
    );

    // hold the ring, pointers and arithmetic; register the result
    sib_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .req_type    (req_type),
        .snap_tick   (snap_tick),
        .query_tick  (query_tick),
        .in_pos_x    (in_pos_x),
        .in_pos_y    (in_pos_y),
        .in_pos_z    (in_pos_z),
        .in_yaw      (in_yaw),
        .in_pitch    (in_pitch),
        .in_flags    (in_flags),
        .done        (done),
        .hit         (hit),
        .accepted    (accepted),
        .out_tick    (out_tick),
        .out_pos_x   (out_pos_x),
        .out_pos_y   (out_pos_y),
        .out_pos_z   (out_pos_z),
        .out_yaw     (out_yaw),
        .out_pitch   (out_pitch),
        .out_flags   (out_flags),
        .entry_count (entry_count)
    );

endmodule

// ===== hw/rtl/sib_dp.sv =====
// Datapath of the snapshot buffer: ring memory, pointers, divider and mixing lanes
module sib_dp import sib_pkg::*; (
    input  logic                     clk,
    input  logic                     rst_n,
    input  dp_cmd_t                  cmd,
    output dp_stat_t                 stat,
    input  logic [REQ_W-1:0]         req_type,
    input  logic [TICK_W-1:0]        snap_tick,
    input  logic [QT_W-1:0]          query_tick,
    input  logic signed [POS_W-1:0]  in_pos_x,
    input  logic signed [POS_W-1:0]  in_pos_y,
    input  logic signed [POS_W-1:0]  in_pos_z,
    input  logic signed [ANG_W-1:0]  in_yaw,
    input  logic signed [ANG_W-1:0]  in_pitch,
    input  logic [FLAG_W-1:0]        in_flags,
    output logic                     done,
    output logic                     hit,
    output logic                     accepted,
    output logic [TICK_W-1:0]        out_tick,
    output logic signed [POS_W-1:0]  out_pos_x,
    output logic signed [POS_W-1:0]  out_pos_y,
    output logic signed [POS_W-1:0]  out_pos_z,
    output logic signed [ANG_W-1:0]  out_yaw,
    output logic signed [ANG_W-1:0]  out_pitch,
    output logic [FLAG_W-1:0]        out_flags,
    output logic [CNT_W-1:0]         entry_count
);

    localparam int D_W  = POS_W + 2;
    localparam int P_W  = D_W + QUO_W;
    localparam logic signed [D_W-1:0] PI_D     = D_W'(PI_Q12);
    localparam logic signed [D_W-1:0] TWO_PI_D = D_W'(TWO_PI_Q12);
    localparam logic signed [P_W-1:0] HALF_P   = P_W'(1 << (T_W - 1));
    localparam logic signed [P_W-1:0] ANG_MAX  = P_W'(32767);
    localparam logic signed [P_W-1:0] ANG_MIN  = -P_W'(32768);
    localparam logic signed [P_W-1:0] POS_MAX  = P_W'(64'sh7FFF_FFFF);
    localparam logic signed [P_W-1:0] POS_MIN  = -P_W'(64'sh8000_0000);

    function automatic logic [SLOT_W-1:0] slot_add(input logic [SLOT_W-1:0] base,
                                                   input logic [CNT_W-1:0] off);
        logic [CNT_W:0] s;
        s = (CNT_W+1)'(base) + (CNT_W+1)'(off);
        if (s >= (CNT_W+1)'(DEPTH))
            s = s - (CNT_W+1)'(DEPTH);
        return s[SLOT_W-1:0];
    endfunction

    entry_t                 ring_reg [DEPTH];
    entry_t                 rdata_reg, snap_reg, ent_a_reg, ent_b_reg;
    logic [REQ_W-1:0]       req_reg;
    logic [QT_W-1:0]        q_reg;
    logic [SLOT_W-1:0]      oldest_reg, oldest_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [SLOT_W-1:0]      k_reg;
    logic [REM_W-1:0]       rem_reg, dsh_reg;
    logic [QUO_W-1:0]       quo_reg;
    logic [BIT_W-1:0]       bit_reg;
    logic [LANE_W-1:0]      lane_reg;
    logic signed [D_W-1:0]  d_reg;
    logic signed [P_W-1:0]  prod_reg;
    logic signed [POS_W-1:0] mix_reg [LANES];
    logic                   done_reg;

    logic [CNT_W-1:0]       rd_off;
    logic [SLOT_W-1:0]      rd_slot, wr_slot;
    logic                   full;
    logic [QT_W-1:0]        rd_tick_q, lo_q;
    logic [T_W-1:0]         t_val;
    logic signed [D_W-1:0]  a_val, b_val, d_val;
    logic                   is_ang;
    logic signed [P_W-1:0]  rnd, sum, sat_val;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign wr_slot = full ? oldest_reg : slot_add(oldest_reg, count_reg);
    assign rd_slot = slot_add(oldest_reg, rd_off);

    always_comb
    begin
        case (cmd.rd_sel)
            RD_FIRST:  rd_off = '0;
            RD_LAST:   rd_off = count_reg - CNT_W'(1);
            RD_SCAN:   rd_off = CNT_W'(k_reg);
            RD_SECOND: rd_off = CNT_W'(1);
            default:   rd_off = '0;
        endcase
    end

    // ring memory, one write and one registered read a cycle
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
            ring_reg[wr_slot] <= snap_reg;
        if (cmd.rd_en)
            rdata_reg <= ring_reg[rd_slot];
    end

    always_comb
    begin
        oldest_next = oldest_reg;
        count_next  = count_reg;
        if (cmd.wr_en)
        begin
            if (full)
                oldest_next = slot_add(oldest_reg, CNT_W'(1));
            else
                count_next = count_reg + CNT_W'(1);
        end
        else if (cmd.advance)
        begin
            oldest_next = slot_add(oldest_reg, CNT_W'(1));
            count_next  = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oldest_reg <= '0;
            count_reg  <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            oldest_reg <= oldest_next;
            count_reg  <= count_next;
            done_reg   <= cmd.fin;
        end
    end

    // status
    assign rd_tick_q = QT_W'(rdata_reg.tick) << TICK_FRAC_BITS;
    assign lo_q      = QT_W'(ent_a_reg.tick) << TICK_FRAC_BITS;
    assign t_val     = quo_reg[QUO_W-1] ? '1 : quo_reg[T_W-1:0];

    always_comb
    begin
        stat.req        = req_reg;
        stat.empty      = (count_reg == '0);
        stat.multi      = (count_reg > CNT_W'(1));
        stat.q_le       = (q_reg <= rd_tick_q);
        stat.q_ge       = (q_reg >= rd_tick_q);
        stat.push_newer = (snap_reg.tick > rdata_reg.tick);
        stat.prune_ok   = (rdata_reg.tick <= q_reg[QT_W-1:TICK_FRAC_BITS]);
        stat.div_last   = (bit_reg == '0);
        stat.lane_last  = (lane_reg == LANE_W'(LANES - 1));
    end

    // lane operands
    always_comb
    begin
        is_ang = 1'b0;
        case (lane_reg)
            3'd0:
            begin
                a_val = D_W'(ent_a_reg.pos_x);
                b_val = D_W'(ent_b_reg.pos_x);
            end
            3'd1:
            begin
                a_val = D_W'(ent_a_reg.pos_y);
                b_val = D_W'(ent_b_reg.pos_y);
            end
            3'd2:
            begin
                a_val = D_W'(ent_a_reg.pos_z);
                b_val = D_W'(ent_b_reg.pos_z);
            end
            3'd3:
            begin
                a_val  = D_W'(ent_a_reg.yaw);
                b_val  = D_W'(ent_b_reg.yaw);
                is_ang = 1'b1;
            end
            default:
            begin
                a_val  = D_W'(ent_a_reg.pitch);
                b_val  = D_W'(ent_b_reg.pitch);
                is_ang = 1'b1;
            end
        endcase
    end

    // difference, wrapped onto the shortest arc for angles
    always_comb
    begin
        d_val = b_val - a_val;
        if (is_ang)
        begin
            for (int i = 0; i < 3; i++)
                if (d_val > PI_D)
                    d_val = d_val - TWO_PI_D;
            for (int i = 0; i < 3; i++)
                if (d_val < -PI_D)
                    d_val = d_val + TWO_PI_D;
        end
    end

    always_comb
    begin
        rnd = (prod_reg + HALF_P) >>> T_W;
        sum = P_W'(a_val) + rnd;
        if (is_ang)
            sat_val = (sum > ANG_MAX) ? ANG_MAX : ((sum < ANG_MIN) ? ANG_MIN : sum);
        else
            sat_val = (sum > POS_MAX) ? POS_MAX : ((sum < POS_MIN) ? POS_MIN : sum);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg        <= req_type;
            q_reg          <= query_tick;
            snap_reg.tick  <= snap_tick;
            snap_reg.pos_x <= in_pos_x;
            snap_reg.pos_y <= in_pos_y;
            snap_reg.pos_z <= in_pos_z;
            snap_reg.yaw   <= in_yaw;
            snap_reg.pitch <= in_pitch;
            snap_reg.flags <= in_flags;
        end
        if (cmd.ent_a_ld)
            ent_a_reg <= rdata_reg;
        if (cmd.ent_b_ld)
            ent_b_reg <= rdata_reg;
        if (cmd.k_set)
            k_reg <= SLOT_W'(1);
        else if (cmd.k_inc)
            k_reg <= k_reg + SLOT_W'(1);
        if (cmd.div_init)
        begin
            rem_reg <= REM_W'(q_reg - lo_q) << (T_W - TICK_FRAC_BITS);
            dsh_reg <= REM_W'(ent_b_reg.tick - ent_a_reg.tick) << T_W;
            quo_reg <= '0;
            bit_reg <= BIT_W'(T_W);
        end
        else if (cmd.div_step)
        begin
            if (rem_reg >= dsh_reg)
            begin
                rem_reg <= rem_reg - dsh_reg;
                quo_reg <= {quo_reg[QUO_W-2:0], 1'b1};
            end
            else
                quo_reg <= {quo_reg[QUO_W-2:0], 1'b0};
            dsh_reg <= dsh_reg >> 1;
            bit_reg <= bit_reg - BIT_W'(1);
        end
        if (cmd.lane_clr)
            lane_reg <= '0;
        else if (cmd.lane_inc)
            lane_reg <= lane_reg + LANE_W'(1);
        if (cmd.lane_d)
            d_reg <= d_val;
        if (cmd.lane_m)
            prod_reg <= P_W'(d_reg) * P_W'($signed({1'b0, t_val}));
        if (cmd.lane_a)
            mix_reg[lane_reg] <= sat_val[POS_W-1:0];
        if (cmd.fin)
        begin
            entry_count <= count_next;
            hit         <= 1'b0;
            accepted    <= 1'b0;
            out_tick    <= '0;
            out_pos_x   <= '0;
            out_pos_y   <= '0;
            out_pos_z   <= '0;
            out_yaw     <= '0;
            out_pitch   <= '0;
            out_flags   <= '0;
            case (cmd.out_sel)
                OUT_PUSH:
                    accepted <= 1'b1;
                OUT_ENTRY:
                begin
                    hit       <= 1'b1;
                    out_tick  <= rdata_reg.tick;
                    out_pos_x <= rdata_reg.pos_x;
                    out_pos_y <= rdata_reg.pos_y;
                    out_pos_z <= rdata_reg.pos_z;
                    out_yaw   <= rdata_reg.yaw;
                    out_pitch <= rdata_reg.pitch;
                    out_flags <= rdata_reg.flags;
                end
                OUT_INTERP:
                begin
                    hit       <= 1'b1;
                    out_tick  <= ent_a_reg.tick;
                    out_pos_x <= mix_reg[0];
                    out_pos_y <= mix_reg[1];
                    out_pos_z <= mix_reg[2];
                    out_yaw   <= mix_reg[3][ANG_W-1:0];
                    out_pitch <= mix_reg[4][ANG_W-1:0];
                    out_flags <= t_val[T_W-1] ? ent_b_reg.flags : ent_a_reg.flags;
                end
                default:
                    hit <= 1'b0;
            endcase
        end
    end

    assign done = done_reg;

endmodule

// ===== hw/rtl/sib_ctrl.sv =====
// Controller state machine of the snapshot buffer
module sib_ctrl import sib_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    localparam logic [3:0] S_IDLE       = 4'd0;
    localparam logic [3:0] S_DISP       = 4'd1;
    localparam logic [3:0] S_PUSH_CMP   = 4'd2;
    localparam logic [3:0] S_CHK_FIRST  = 4'd3;
    localparam logic [3:0] S_CHK_LAST   = 4'd4;
    localparam logic [3:0] S_SCAN_RD    = 4'd5;
    localparam logic [3:0] S_SCAN_CHK   = 4'd6;
    localparam logic [3:0] S_DIV_INIT   = 4'd7;
    localparam logic [3:0] S_DIV        = 4'd8;
    localparam logic [3:0] S_MIX_D      = 4'd9;
    localparam logic [3:0] S_MIX_M      = 4'd10;
    localparam logic [3:0] S_MIX_A      = 4'd11;
    localparam logic [3:0] S_SMP_FIN    = 4'd12;
    localparam logic [3:0] S_PR_RD      = 4'd13;
    localparam logic [3:0] S_PR_CMP     = 4'd14;

    logic [3:0] state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                cmd.load = start;
                if (start)
                    state_next = S_DISP;
            end
            S_DISP:
            begin
                case (stat.req)
                    REQ_PUSH:
                    begin
                        if (stat.empty)
                        begin
                            cmd.wr_en   = 1'b1;
                            cmd.fin     = 1'b1;
                            cmd.out_sel = OUT_PUSH;
                            state_next  = S_IDLE;
                        end
                        else
                        begin
                            cmd.rd_en  = 1'b1;
                            cmd.rd_sel = RD_LAST;
                            state_next = S_PUSH_CMP;
                        end
                    end
                    REQ_SAMPLE:
                    begin
                        if (stat.empty)
                        begin
                            cmd.fin    = 1'b1;
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            cmd.rd_en  = 1'b1;
                            cmd.rd_sel = RD_FIRST;
                            state_next = S_CHK_FIRST;
                        end
                    end
                    REQ_PRUNE:
                        state_next = S_PR_RD;
                    default:
                    begin
                        cmd.fin    = 1'b1;
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_PUSH_CMP:
            begin
                cmd.fin     = 1'b1;
                cmd.wr_en   = stat.push_newer;
                cmd.out_sel = stat.push_newer ? OUT_PUSH : OUT_NONE;
                state_next  = S_IDLE;
            end
            S_CHK_FIRST:
            begin
                if (stat.q_le)
                begin
                    cmd.fin     = 1'b1;
                    cmd.out_sel = OUT_ENTRY;
                    state_next  = S_IDLE;
                end
                else
                begin
                    cmd.ent_a_ld = 1'b1;
                    cmd.rd_en    = 1'b1;
                    cmd.rd_sel   = RD_LAST;
                    state_next   = S_CHK_LAST;
                end
            end
            S_CHK_LAST:
            begin
                if (stat.q_ge)
                begin
                    cmd.fin     = 1'b1;
                    cmd.out_sel = OUT_ENTRY;
                    state_next  = S_IDLE;
                end
                else
                begin
                    cmd.k_set  = 1'b1;
                    state_next = S_SCAN_RD;
                end
            end
            S_SCAN_RD:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_SCAN;
                state_next = S_SCAN_CHK;
            end
            S_SCAN_CHK:
            begin
                if (stat.q_le)
                begin
                    cmd.ent_b_ld = 1'b1;
                    state_next   = S_DIV_INIT;
                end
                else
                begin
                    cmd.ent_a_ld = 1'b1;
                    cmd.k_inc    = 1'b1;
                    state_next   = S_SCAN_RD;
                end
            end
            S_DIV_INIT:
            begin
                cmd.div_init = 1'b1;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                begin
                    cmd.lane_clr = 1'b1;
                    state_next   = S_MIX_D;
                end
            end
            S_MIX_D:
            begin
                cmd.lane_d = 1'b1;
                state_next = S_MIX_M;
            end
            S_MIX_M:
            begin
                cmd.lane_m = 1'b1;
                state_next = S_MIX_A;
            end
            S_MIX_A:
            begin
                cmd.lane_a = 1'b1;
                if (stat.lane_last)
                    state_next = S_SMP_FIN;
                else
                begin
                    cmd.lane_inc = 1'b1;
                    state_next   = S_MIX_D;
                end
            end
            S_SMP_FIN:
            begin
                cmd.fin     = 1'b1;
                cmd.out_sel = OUT_INTERP;
                state_next  = S_IDLE;
            end
            S_PR_RD:
            begin
                if (stat.multi)
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_SECOND;
                    state_next = S_PR_CMP;
                end
                else
                begin
                    cmd.fin    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_PR_CMP:
            begin
                if (stat.prune_ok)
                begin
                    cmd.advance = 1'b1;
                    state_next  = S_PR_RD;
                end
                else
                begin
                    cmd.fin    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

endmodule

// ===== hw/rtl/sib_checker.sv =====
// Port-level checker of the snapshot buffer and its bind
`include "snapshot_interpolation_buffer_unit_assert.svh"
module sib_checker import sib_pkg::*; (
    input logic             clk,
    input logic             rst_n,
    input logic             start,
    input logic             busy,
    input logic             done,
    input logic             hit,
    input logic             accepted,
    input logic [CNT_W-1:0] entry_count
);

    `SIB_ASSERT_NEXT(a_start_busy, start && !busy, busy)
    `SIB_ASSERT_NOW(a_done_idle, done, !busy)
    `SIB_ASSERT_NOW(a_fell_done, $fell(busy), done)
    `SIB_ASSERT_NOW(a_count_max, done, entry_count <= CNT_W'(DEPTH))
    `SIB_ASSERT_NOW(a_hit_push, done && accepted, !hit)

endmodule

bind snapshot_interpolation_buffer_unit sib_checker u_sib_checker (.*);
